### rtl/core/jackknife_bin_means_core_assert.svh
// Assertion macros shared by the RTL of the jackknife bin-means core.
`ifndef JACKKNIFE_BIN_MEANS_CORE_ASSERT_SVH
`define JACKKNIFE_BIN_MEANS_CORE_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define JBM_ASSERT_IMPL(lbl, clk_s, rstn_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
		else $error("jackknife_bin_means_core: same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define JBM_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
		else $error("jackknife_bin_means_core: next-cycle check failed");

`endif

### rtl/core/jbm_pkg.sv
package jbm_pkg;

	// Configuration port.
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BIN_SIZE     = 8'd1;

	localparam logic [15:0] SAMPLE_COUNT_RST = 16'd1024;
	localparam logic [15:0] BIN_SIZE_RST     = 16'd16;

	// Result status codes.
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_BAD_BINS = 2'd1;
	localparam logic [1:0] ST_ZERO_DIV = 2'd2;

	// Field widths fixed by the stream format.
	localparam int SAMPLE_W = 32;
	localparam int BIN_W    = 6;
	localparam int MEAN_W   = 32;

	localparam logic [MEAN_W-1:0] MEAN_MAX = 32'h7FFF_FFFF;
	localparam logic [MEAN_W-1:0] MEAN_MIN = 32'h8000_0000;

	// Divisor width of the shared divider.
	localparam int DIV_W = 16;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

### rtl/core/jbm_div.sv
// Restoring divider, one quotient bit per clock. The quotient and remainder
// stay in their registers until the next start.
module jbm_div #(
	parameter int DVD_W = 48
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [DVD_W-1:0]             dividend,
	input  logic [jbm_pkg::DIV_W-1:0]    divisor,
	output logic [DVD_W-1:0]             quot,
	output logic [jbm_pkg::DIV_W-1:0]    rem,
	output jbm_pkg::div_stat_t           stat
);

	localparam int CNT_W = $clog2(DVD_W + 1);

	logic [DVD_W-1:0]          quo_q;
	logic [jbm_pkg::DIV_W-1:0] rem_q;
	logic [jbm_pkg::DIV_W-1:0] dvs_q;
	logic [CNT_W-1:0]          cnt_q;
	logic                      busy_q;
	logic                      done_q;

	logic [jbm_pkg::DIV_W:0]   trial;
	logic                      ge;
	logic [jbm_pkg::DIV_W-1:0] rem_nxt;

	always_comb begin
		trial   = {rem_q, quo_q[DVD_W-1]};
		ge      = (trial >= {1'b0, dvs_q});
		rem_nxt = ge ? jbm_pkg::DIV_W'(trial - {1'b0, dvs_q}) : trial[jbm_pkg::DIV_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DVD_W-2:0], ge};
			rem_q <= rem_nxt;
		end
	end

	assign quot      = quo_q;
	assign rem       = rem_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

### rtl/core/jackknife_bin_means_core.sv
// Delete-one-bin jackknife means over a series of signed Q16.16 samples. The
// core reads the sample count and the nominal bin length registers at the first
// sample of each series, splits the series into sample_count / bin length bins
// (the remainder is dealt out one sample per bin from bin 0 on, wrapping
// around), keeps a running total and one sum per bin, and after the last
// sample emits one beat per bin carrying the mean of all samples outside that
// bin, rounded to nearest with ties away from zero and saturated to the Q16.16
// range. A zero bin length, or a bin count of zero or above MAX_BINS, yields
// a single beat with status 1, a single bin spanning the whole series a
// single beat with status 2; in both cases the series still consumes
// sample_count samples. Rate: samples are taken one per clock, except the
// first sample of a series, which waits while the shared restoring divider
// works out the bin count and remainder split over ACC_W-bit dividends (ACC_W
// is 48 at the default SAMPLE_WIDTH). At the end of a series the same divider
// produces one mean per bin, one quotient bit per clock, as long as the output
// register is free to take it, and the input is held off until the last result
// has been handed to the output register. A result waiting in that register
// does not stop the core from taking the next series. Configuration writes are
// taken at any time and apply from the next series on.
`include "jackknife_bin_means_core_assert.svh"

module jackknife_bin_means_core #(
	parameter int MAX_BINS     = 64,
	parameter int SAMPLE_WIDTH = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,

	// Configuration write channel.
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [jbm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [jbm_pkg::CFG_DATA_W-1:0]  cfg_data,

	// Sample stream. tdata: sample[31:0].
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [jbm_pkg::SAMPLE_W-1:0]    s_tdata,

	// Result stream. tdata: bin_index[5:0], jk_mean[37:6], status[39:38].
	// tlast marks the final result of a series.
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [39:0]                     m_tdata,
	output logic                            m_tlast
);

	// Sums carry 16 bits of headroom over the sample, and never fewer than 48
	// bits so that the saturation check always has bit 31 and above to look at.
	localparam int ACC_W = (SAMPLE_WIDTH + 16 > 48) ? SAMPLE_WIDTH + 16 : 48;
	localparam int CB_W  = $clog2(MAX_BINS + 1);
	localparam int IDX_W = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;

	typedef enum logic [3:0] {
		S_IDLE,
		S_GEO0,
		S_GEO1,
		S_GEO2,
		S_FIRST,
		S_OBIN,
		S_ORD,
		S_ONEG,
		S_ODIV,
		S_OSAT,
		S_LOAD
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [15:0] cfg_count_q;
	logic [15:0] cfg_bsize_q;

	// Geometry latched for the running series.
	logic [15:0] cnt_q;
	logic [15:0] base_q;
	logic [15:0] nb_q;
	logic [15:0] xq_q;
	logic [15:0] xr_q;
	logic [1:0]  geo_status_q;

	// Accumulation state.
	logic [ACC_W-1:0] total_q;
	logic [ACC_W-1:0] bin_acc_q;
	logic [15:0]      seen_q;
	logic [CB_W-1:0]  cur_bin_q;
	logic [16:0]      left_q;
	logic [jbm_pkg::SAMPLE_W-1:0] sample_q;

	// Finished bin sums, written once per bin as the bin closes.
	logic [ACC_W-1:0] bin_mem_q [MAX_BINS];
	logic [ACC_W-1:0] rd_data_q;

	// Result computation.
	logic [CB_W-1:0]   obin_q;
	logic [ACC_W-1:0]  num_q;
	logic [15:0]       d_q;
	logic              neg_q;
	logic [ACC_W:0]    qr_q;
	logic [jbm_pkg::MEAN_W-1:0] res_mean_q;
	logic [1:0]        res_status_q;
	logic              res_last_q;

	// Output register.
	logic                       m_tvalid_q;
	logic [jbm_pkg::BIN_W-1:0]  out_bin_q;
	logic [jbm_pkg::MEAN_W-1:0] out_mean_q;
	logic [1:0]                 out_status_q;
	logic                       out_last_q;

	// Shared divider.
	logic                       div_start;
	logic [ACC_W-1:0]           div_dividend;
	logic [jbm_pkg::DIV_W-1:0]  div_divisor;
	logic [ACC_W-1:0]           div_quot;
	logic [jbm_pkg::DIV_W-1:0]  div_rem;
	jbm_pkg::div_stat_t         div_stat;

	// Combinational helpers.
	logic [jbm_pkg::SAMPLE_W-1:0] smp_raw;
	logic [ACC_W-1:0]  smp_ext;
	logic              step_en;
	logic              bin_open;
	logic [ACC_W-1:0]  acc_sum;
	logic [16:0]       left_dec;
	logic              bin_close;
	logic [CB_W-1:0]   cur_inc;
	logic [16:0]       seen_inc;
	logic              series_end;
	logic              mem_re;
	logic              load_ok;
	logic              obin_last;
	logic              geo_nb_ok;
	logic [ACC_W-1:0]  mag;
	logic              round_up;
	logic              sat_hi;
	logic [jbm_pkg::MEAN_W-1:0] sat_mean;

	// Samples in bin idx: base plus the even share of the remainder, plus one
	// for the bins that pick up the leftover.
	function automatic logic [16:0] bin_span_of(input logic [CB_W-1:0] idx,
			input logic [15:0] b, input logic [15:0] xq, input logic [15:0] xr);
		logic ext;
		ext = (16'(idx) < xr);
		return {1'b0, b} + {1'b0, xq} + 17'(ext);
	endfunction

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == S_IDLE);
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = {out_status_q, out_mean_q, out_bin_q};
	assign m_tlast   = out_last_q;

	// The first sample of a series waits in sample_q while the geometry is
	// worked out; every later sample is folded in on the cycle it arrives.
	assign smp_raw = (state_q == S_FIRST) ? sample_q : s_tdata;

	generate
		if (SAMPLE_WIDTH <= jbm_pkg::SAMPLE_W) begin : g_sext
			assign smp_ext = ACC_W'($signed(smp_raw[SAMPLE_WIDTH-1:0]));
		end else begin : g_zext
			assign smp_ext = ACC_W'(smp_raw);
		end
	endgenerate

	always_comb begin
		step_en    = (state_q == S_FIRST) ||
		             (s_tvalid && (state_q == S_IDLE) && (seen_q != '0));
		bin_open   = (geo_status_q == jbm_pkg::ST_OK) && (16'(cur_bin_q) < nb_q);
		acc_sum    = bin_acc_q + smp_ext;
		left_dec   = (left_q != '0) ? left_q - 17'd1 : left_q;
		bin_close  = bin_open && (left_dec == '0);
		cur_inc    = cur_bin_q + CB_W'(1);
		seen_inc   = {1'b0, seen_q} + 17'd1;
		series_end = (seen_inc >= {1'b0, cnt_q});
		mem_re     = (state_q == S_OBIN) && (geo_status_q == jbm_pkg::ST_OK);
		load_ok    = !m_tvalid_q || m_tready;
		obin_last  = ((16'(obin_q) + 16'd1) == nb_q);
		geo_nb_ok  = (div_quot[15:0] != '0) && (div_quot[15:0] <= 16'(MAX_BINS));
		mag        = num_q[ACC_W-1] ? ('0 - num_q) : num_q;
		round_up   = ({div_rem, 1'b0} >= {1'b0, d_q});
		sat_hi     = |qr_q[ACC_W:31];
		if (neg_q) begin
			sat_mean = sat_hi ? jbm_pkg::MEAN_MIN : (32'd0 - qr_q[31:0]);
		end else begin
			sat_mean = sat_hi ? jbm_pkg::MEAN_MAX : qr_q[31:0];
		end
	end

	// Divider operand selection: bin count, then remainder split, then one
	// mean per bin.
	always_comb begin
		div_start    = 1'b0;
		div_dividend = ACC_W'(cnt_q);
		div_divisor  = base_q;
		case (state_q)
			S_GEO0: begin
				div_start = (base_q != '0);
			end
			S_GEO1: begin
				div_start    = div_stat.done && geo_nb_ok;
				div_dividend = ACC_W'(div_rem);
				div_divisor  = div_quot[15:0];
			end
			S_ONEG: begin
				div_start    = (d_q != '0);
				div_dividend = mag;
				div_divisor  = d_q;
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	jbm_div #(
		.DVD_W (ACC_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.quot     (div_quot),
		.rem      (div_rem),
		.stat     (div_stat)
	);

	always_ff @(posedge clk) begin
		if (step_en && bin_close) begin
			bin_mem_q[cur_bin_q[IDX_W-1:0]] <= acc_sum;
		end
		if (mem_re) begin
			rd_data_q <= bin_mem_q[obin_q[IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cfg_count_q  <= jbm_pkg::SAMPLE_COUNT_RST;
			cfg_bsize_q  <= jbm_pkg::BIN_SIZE_RST;
			cnt_q        <= '0;
			base_q       <= '0;
			nb_q         <= '0;
			xq_q         <= '0;
			xr_q         <= '0;
			geo_status_q <= jbm_pkg::ST_OK;
			total_q      <= '0;
			bin_acc_q    <= '0;
			seen_q       <= '0;
			cur_bin_q    <= '0;
			left_q       <= '0;
			obin_q       <= '0;
			m_tvalid_q   <= 1'b0;
			res_last_q   <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					jbm_pkg::REG_SAMPLE_COUNT: cfg_count_q <= cfg_data;
					jbm_pkg::REG_BIN_SIZE:     cfg_bsize_q <= cfg_data;
					default: begin
					end
				endcase
			end

			// In S_LOAD the output register is refilled below instead.
			if (m_tvalid_q && m_tready && (state_q != S_LOAD)) begin
				m_tvalid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					// A new series: latch the configuration and clear the sums.
					if (s_tvalid && (seen_q == '0)) begin
						cnt_q     <= cfg_count_q;
						base_q    <= cfg_bsize_q;
						sample_q  <= s_tdata;
						total_q   <= '0;
						bin_acc_q <= '0;
						cur_bin_q <= '0;
						state_q   <= S_GEO0;
					end
				end
				S_GEO0: begin
					if (base_q == '0) begin
						nb_q         <= '0;
						xq_q         <= '0;
						xr_q         <= '0;
						geo_status_q <= jbm_pkg::ST_BAD_BINS;
						left_q       <= '0;
						state_q      <= S_FIRST;
					end else begin
						state_q <= S_GEO1;
					end
				end
				S_GEO1: begin
					if (div_stat.done) begin
						nb_q <= div_quot[15:0];
						if (geo_nb_ok) begin
							state_q <= S_GEO2;
						end else begin
							xq_q         <= '0;
							xr_q         <= '0;
							geo_status_q <= jbm_pkg::ST_BAD_BINS;
							left_q       <= '0;
							state_q      <= S_FIRST;
						end
					end
				end
				S_GEO2: begin
					if (div_stat.done) begin
						xq_q <= div_quot[15:0];
						xr_q <= div_rem;
						if (nb_q == 16'd1) begin
							geo_status_q <= jbm_pkg::ST_ZERO_DIV;
							left_q       <= '0;
						end else begin
							geo_status_q <= jbm_pkg::ST_OK;
							left_q       <= {1'b0, base_q} + {1'b0, div_quot[15:0]} +
							                17'(div_rem != '0);
						end
						state_q <= S_FIRST;
					end
				end
				S_FIRST: begin
					// The step below moves on from here.
				end
				S_OBIN: begin
					if (geo_status_q != jbm_pkg::ST_OK) begin
						res_mean_q   <= '0;
						res_status_q <= geo_status_q;
						res_last_q   <= 1'b1;
						state_q      <= S_LOAD;
					end else begin
						state_q <= S_ORD;
					end
				end
				S_ORD: begin
					num_q      <= total_q - rd_data_q;
					d_q        <= 16'({1'b0, cnt_q} -
					                  bin_span_of(obin_q, base_q, xq_q, xr_q));
					res_last_q <= obin_last;
					state_q    <= S_ONEG;
				end
				S_ONEG: begin
					neg_q <= num_q[ACC_W-1];
					if (d_q == '0) begin
						res_mean_q   <= '0;
						res_status_q <= jbm_pkg::ST_ZERO_DIV;
						state_q      <= S_LOAD;
					end else begin
						state_q <= S_ODIV;
					end
				end
				S_ODIV: begin
					if (div_stat.done) begin
						qr_q    <= {1'b0, div_quot} + (ACC_W + 1)'(round_up);
						state_q <= S_OSAT;
					end
				end
				S_OSAT: begin
					res_mean_q   <= sat_mean;
					res_status_q <= jbm_pkg::ST_OK;
					state_q      <= S_LOAD;
				end
				S_LOAD: begin
					if (load_ok) begin
						m_tvalid_q   <= 1'b1;
						out_bin_q    <= jbm_pkg::BIN_W'(obin_q);
						out_mean_q   <= res_mean_q;
						out_status_q <= res_status_q;
						out_last_q   <= res_last_q;
						if (res_last_q) begin
							state_q <= S_IDLE;
						end else begin
							obin_q  <= obin_q + CB_W'(1);
							state_q <= S_OBIN;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			// One sample folded into the total and the open bin.
			if (step_en) begin
				total_q <= total_q + smp_ext;
				if (bin_open) begin
					if (left_dec == '0) begin
						cur_bin_q <= cur_inc;
						bin_acc_q <= '0;
						if (16'(cur_inc) < nb_q) begin
							left_q <= bin_span_of(cur_inc, base_q, xq_q, xr_q);
						end else begin
							left_q <= left_dec;
						end
					end else begin
						left_q    <= left_dec;
						bin_acc_q <= acc_sum;
					end
				end
				if (series_end) begin
					seen_q  <= '0;
					obin_q  <= '0;
					state_q <= S_OBIN;
				end else begin
					seen_q  <= seen_inc[15:0];
					state_q <= S_IDLE;
				end
			end
		end
	end

	`JBM_ASSERT_IMPL(a_div_not_restarted, clk, arst_n, div_start, !div_stat.busy)
	`JBM_ASSERT_IMPL(a_bin_in_range, clk, arst_n,
		(state_q == S_IDLE) && (geo_status_q == jbm_pkg::ST_OK), 16'(cur_bin_q) <= nb_q)
	`JBM_ASSERT_IMPL(a_open_bin_has_room, clk, arst_n,
		(state_q == S_IDLE) && bin_open, left_q != '0)
	`JBM_ASSERT_NEXT(a_last_beat_ends_series, clk, arst_n,
		(state_q == S_LOAD) && load_ok && res_last_q,
		(state_q == S_IDLE) && m_tvalid_q && m_tlast && (seen_q == '0))

endmodule
